>>> sv/huffman_code_bit_packer_defines.svh
// assertion macros shared by the huffman code bit packer rtl
`ifndef HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH

// condition in this cycle implies a consequence in the same cycle
`define HCBP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition in this cycle implies a consequence in the next cycle
`define HCBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/hcbp_pkg.sv
// shared constants and command codes of the huffman code bit packer
package hcbp_pkg;

	// fixed field widths of the input item
	localparam int SYMBOL_W    = 16;
	localparam int CODE_BITS_W = 32;
	localparam int CODE_LEN_W  = 6;
	localparam int CMD_W       = 2;

	// parameter defaults
	localparam int SYMBOL_COUNT_DEF = 65536;
	localparam int MAX_CODE_LEN_DEF = 32;
	localparam int WORD_BITS_DEF    = 16;

	// item commands; code 3 does nothing
	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD   = 2'd0,
		CMD_ENCODE = 2'd1,
		CMD_FLUSH  = 2'd2
	} cmd_t;

endpackage

>>> sv/hcbp_code_table.sv
// code table memory: length saturation and bit masking on write, registered read
module hcbp_code_table #(
	parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF,
	parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
	localparam int AW = $clog2(SYMBOL_COUNT),
	localparam int CW = MAX_CODE_LEN,
	localparam int LW = $clog2(MAX_CODE_LEN + 1)
) (
	input  logic                               clk,
	input  logic                               wr_en,
	input  logic [AW-1:0]                      wr_addr,
	input  logic [hcbp_pkg::CODE_BITS_W-1:0]   wr_code,
	input  logic [hcbp_pkg::CODE_LEN_W-1:0]    wr_len,
	input  logic                               rd_en,
	input  logic [AW-1:0]                      rd_addr,
	output logic [CW-1:0]                      rd_code,
	output logic [LW-1:0]                      rd_len
);

	localparam int CMPW = (hcbp_pkg::CODE_LEN_W > LW ? hcbp_pkg::CODE_LEN_W : LW) + 1;

	logic [CW+LW-1:0] mem [SYMBOL_COUNT];
	logic [LW-1:0]    len_sat;
	logic [CW-1:0]    code_masked;
	logic [CW+LW-1:0] rd_word_q;

	// saturate the length, then drop code bits above it
	always_comb begin
		if (CMPW'(wr_len) > CMPW'(MAX_CODE_LEN)) begin
			len_sat = LW'(MAX_CODE_LEN);
		end else begin
			len_sat = LW'(wr_len);
		end
		code_masked = CW'(wr_code) & ~({CW{1'b1}} << len_sat);
	end

	// single write port, single registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {len_sat, code_masked};
		end
		if (rd_en) begin
			rd_word_q <= mem[rd_addr];
		end
	end

	assign rd_code = rd_word_q[CW-1:0];
	assign rd_len  = rd_word_q[CW+LW-1:CW];

endmodule

>>> sv/huffman_code_bit_packer.sv
// huffman code bit packer: code table lookup and msb-first word packing
//
//  channel  | direction | contents
//  s_*      | in        | item: tuser command, tdata symbol / code bits / code length
//  m_*      | out       | item: tdata packed word / pad bits, tlast last word of item
//
// a load needs no state beyond idle; an encode reads the table in ST_LOOKUP, then packs
// in ST_EMIT one word per cycle while the output slot is free, merging the tail into the
// pending word; a flush passes through ST_FLUSH. one item is worked on at a time.
// reset clears the pending word and count; the code table is not cleared.
// a full output register holds packing while m_tready is low.
`include "huffman_code_bit_packer_defines.svh"

module huffman_code_bit_packer #(
	parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF,
	parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
	parameter int WORD_BITS    = hcbp_pkg::WORD_BITS_DEF,
	localparam int PW          = $clog2(WORD_BITS + 1),
	localparam int OUT_W       = ((WORD_BITS + PW + 7) / 8) * 8,
	localparam int IN_W        = ((hcbp_pkg::SYMBOL_W + hcbp_pkg::CODE_BITS_W
		+ hcbp_pkg::CODE_LEN_W + 7) / 8) * 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [IN_W-1:0]            s_tdata,   // symbol, code_bits, code_length, zero fill
	input  logic [hcbp_pkg::CMD_W-1:0] s_tuser,   // command
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [OUT_W-1:0]           m_tdata,   // packed_word, pad_bits, zero fill
	output logic                       m_tlast
);

	localparam int AW   = $clog2(SYMBOL_COUNT);
	localparam int CW   = MAX_CODE_LEN;
	localparam int LW   = $clog2(MAX_CODE_LEN + 1);
	localparam int CNTW = $clog2(WORD_BITS);
	localparam int SW   = (LW > PW ? LW : PW);
	localparam int WW   = WORD_BITS + CW;
	localparam int SYMW = hcbp_pkg::SYMBOL_W;
	localparam int CBW  = hcbp_pkg::CODE_BITS_W;
	localparam int CLW  = hcbp_pkg::CODE_LEN_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_EMIT,
		ST_FLUSH
	} state_t;

	state_t                 state_q;
	logic [WORD_BITS-1:0]   pend_q;
	logic [CNTW-1:0]        cnt_q;
	logic [CW-1:0]          code_q;
	logic [LW-1:0]          rem_q;
	logic                   out_valid_q;
	logic [WORD_BITS-1:0]   word_q;
	logic [PW-1:0]          pad_q;
	logic                   last_q;

	hcbp_pkg::cmd_t         cmd;
	logic [SYMW-1:0]        symbol;
	logic [CBW-1:0]         code_bits;
	logic [CLW-1:0]         code_length;
	logic                   in_accept;
	logic                   in_range;
	logic                   tbl_wr;
	logic                   tbl_rd;
	logic [CW-1:0]          rd_code;
	logic [LW-1:0]          rd_len;

	logic                   slot_free;
	logic [PW-1:0]          avail;
	logic [SW-1:0]          rem_x;
	logic [SW-1:0]          avail_x;
	logic [SW-1:0]          new_rem;
	logic                   emit_need;
	logic                   emit_fire;
	logic                   flush_fire;
	logic [WORD_BITS-1:0]   emit_word;
	logic [WORD_BITS-1:0]   merge_word;
	logic [WORD_BITS-1:0]   flush_word;
	logic [CW-1:0]          code_left;
	logic                   emit_last;

	// input unpacking and acceptance
	assign cmd         = hcbp_pkg::cmd_t'(s_tuser);
	assign symbol      = s_tdata[SYMW-1:0];
	assign code_bits   = s_tdata[SYMW+CBW-1:SYMW];
	assign code_length = s_tdata[SYMW+CBW+CLW-1:SYMW+CBW];
	assign s_tready    = (state_q == ST_IDLE);
	assign in_accept   = s_tvalid && s_tready;
	assign in_range    = ((SYMW+1)'(symbol) < (SYMW+1)'(SYMBOL_COUNT));
	assign tbl_wr      = in_accept && (cmd == hcbp_pkg::CMD_LOAD) && in_range;
	assign tbl_rd      = in_accept && (cmd == hcbp_pkg::CMD_ENCODE) && in_range;

	hcbp_code_table #(
		.SYMBOL_COUNT (SYMBOL_COUNT),
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_code_table (
		.clk     (clk),
		.wr_en   (tbl_wr),
		.wr_addr (symbol[AW-1:0]),
		.wr_code (code_bits),
		.wr_len  (code_length),
		.rd_en   (tbl_rd),
		.rd_addr (symbol[AW-1:0]),
		.rd_code (rd_code),
		.rd_len  (rd_len)
	);

	// packing step: fill the pending word from the top of the remaining code
	always_comb begin
		slot_free  = !out_valid_q || m_tready;
		avail      = PW'(WORD_BITS) - PW'(cnt_q);
		rem_x      = SW'(rem_q);
		avail_x    = SW'(avail);
		emit_need  = (rem_x >= avail_x);
		new_rem    = rem_x - avail_x;
		emit_word  = WORD_BITS'((WW'(pend_q) << avail) | (WW'(code_q) >> new_rem));
		merge_word = WORD_BITS'((WW'(pend_q) << rem_q) | WW'(code_q));
		code_left  = code_q & ~({CW{1'b1}} << new_rem);
		emit_last  = (new_rem < SW'(WORD_BITS));
		flush_word = pend_q << avail;
		emit_fire  = (state_q == ST_EMIT) && emit_need && slot_free;
		flush_fire = (state_q == ST_FLUSH) && slot_free;
	end

	// sequencer and pending state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pend_q      <= '0;
			cnt_q       <= '0;
			code_q      <= '0;
			rem_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (tbl_rd) begin
						state_q <= ST_LOOKUP;
					end else if (in_accept && (cmd == hcbp_pkg::CMD_FLUSH)) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_LOOKUP: begin
					code_q  <= rd_code;
					rem_q   <= rd_len;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_need) begin
						if (slot_free) begin
							pend_q      <= '0;
							cnt_q       <= '0;
							code_q      <= code_left;
							rem_q       <= LW'(new_rem);
							if (new_rem == '0) begin
								state_q <= ST_IDLE;
							end
						end
					end else begin
						pend_q  <= merge_word;
						cnt_q   <= CNTW'(SW'(cnt_q) + rem_x);
						rem_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_FLUSH: begin
					if (slot_free) begin
						pend_q      <= '0;
						cnt_q       <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output valid: set by a new word, cleared when the waiting word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire || flush_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output item register
	always_ff @(posedge clk) begin
		if (emit_fire) begin
			word_q <= emit_word;
			pad_q  <= '0;
			last_q <= emit_last;
		end else if (flush_fire) begin
			word_q <= flush_word;
			pad_q  <= avail;
			last_q <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({pad_q, word_q});
	assign m_tlast  = last_q;

	// a flush always leaves a padded last word
	`HCBP_ASSERT_NEXT(a_flush_pads, clk, arst_n, flush_fire,
		out_valid_q && last_q && (pad_q != '0) && (cnt_q == '0), "flush word not padded")
	// a full word carries no pad and empties the pending word
	`HCBP_ASSERT_NEXT(a_full_word, clk, arst_n, emit_fire,
		out_valid_q && (pad_q == '0) && (cnt_q == '0) && (pend_q == '0), "full word wrong")
	// a load leaves the pending bits alone
	`HCBP_ASSERT_NEXT(a_load_keeps, clk, arst_n, in_accept && (cmd == hcbp_pkg::CMD_LOAD),
		$stable(pend_q) && $stable(cnt_q) && (state_q == ST_IDLE), "load disturbed packer")
	// packing never overwrites an item still waiting at the output
	`HCBP_ASSERT_SAME(a_no_overwrite, clk, arst_n, emit_fire || flush_fire,
		!out_valid_q || m_tready, "output item overwritten")

endmodule
